>>> rtl/vrg_pkg.sv
// Package for the voltage ramp generator: status codes, result kinds and the
// command and status structs that join the controller and the datapath.
// No dependencies.
package vrg_pkg;

    // Width and reset value of the ramp threshold register.
    localparam int unsigned THRESH_BITS  = 21;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 21'd50000;

    // Status codes carried with each result item.
    localparam logic [1:0] ST_STEP    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    // Kinds of result the controller can ask the datapath to form.
    typedef enum logic [2:0] {
        RK_STEP,
        RK_DONE_LEVEL,
        RK_BUSY,
        RK_REFUSED,
        RK_SET_ZERO,
        RK_SET_TARGET
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      tick_inc;
        logic      tick_clr;
        logic      step_adv;
        logic      div_start;
        logic      ramp_load;
        logic      res_load;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic chan_on;
        logic target_zero;
        logic below_thr;
        logic steps_zero;
        logic tick_hit;
        logic steps_left_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/vrg_divider.sv
// Restoring serial divider for the ramp generator: two dividends share one
// divisor and one quotient bit of each is found per cycle.
// Depends on nothing but its parameters.
module vrg_divider #(
    parameter int unsigned N_BITS = 23,
    parameter int unsigned D_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_dividend_a,
    input  logic [N_BITS-1:0] i_dividend_b,
    input  logic [D_BITS-1:0] i_divisor,
    output logic              o_done,
    output logic [N_BITS-1:0] o_quot_a,
    output logic [N_BITS-1:0] o_quot_b
);

    localparam int unsigned CNT_BITS = $clog2(N_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [N_BITS-1:0]   r_qa;
    logic [N_BITS-1:0]   r_qb;
    logic [D_BITS-1:0]   r_rema;
    logic [D_BITS-1:0]   r_remb;

    logic [D_BITS:0]     w_ta;
    logic [D_BITS:0]     w_tb;
    logic [D_BITS:0]     w_da;
    logic [D_BITS:0]     w_db;
    logic                w_ge_a;
    logic                w_ge_b;
    logic [D_BITS-1:0]   n_rema;
    logic [D_BITS-1:0]   n_remb;

    // Trial subtraction for both partial remainders.
    always_comb begin
        w_ta   = {r_rema, r_qa[N_BITS-1]};
        w_tb   = {r_remb, r_qb[N_BITS-1]};
        w_da   = w_ta - {1'b0, i_divisor};
        w_db   = w_tb - {1'b0, i_divisor};
        w_ge_a = (w_ta >= {1'b0, i_divisor});
        w_ge_b = (w_tb >= {1'b0, i_divisor});
        n_rema = w_ge_a ? w_da[D_BITS-1:0] : w_ta[D_BITS-1:0];
        n_remb = w_ge_b ? w_db[D_BITS-1:0] : w_tb[D_BITS-1:0];
    end

    // Iteration control; the dividends shift out as the quotients shift in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(N_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qa   <= i_dividend_a;
            r_qb   <= i_dividend_b;
            r_rema <= '0;
            r_remb <= '0;
        end else if (r_busy) begin
            r_qa   <= {r_qa[N_BITS-2:0], w_ge_a};
            r_qb   <= {r_qb[N_BITS-2:0], w_ge_b};
            r_rema <= n_rema;
            r_remb <= n_remb;
        end
    end

    assign o_done   = r_done;
    assign o_quot_a = r_qa;
    assign o_quot_b = r_qb;

endmodule

>>> rtl/vrg_datapath.sv
// Datapath of the voltage ramp generator: captured request, threshold
// register, ramp state, pending result and output register.
// Depends on vrg_pkg and vrg_divider.
module vrg_datapath
    import vrg_pkg::*;
#(
    parameter int unsigned VOLT_BITS = 22,
    parameter int unsigned STEP_BITS = 16,
    parameter int unsigned SPAN_BITS = 20,
    parameter int unsigned IN_W      = 88,
    parameter int unsigned OUT_W     = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_W-1:0]        i_in_data,
    input  logic                   i_in_user,
    input  logic                   i_cfg_valid,
    input  logic [THRESH_BITS-1:0] i_cfg_data,
    input  logic                   i_out_ready,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    output logic [OUT_W-1:0]       o_out_data,
    output logic [2:0]             o_out_user,
    output logic                   o_out_last
);

    localparam int unsigned VB      = VOLT_BITS;
    localparam int unsigned OFF_STP = VB;
    localparam int unsigned OFF_SPN = OFF_STP + STEP_BITS;
    localparam int unsigned OFF_PRS = OFF_SPN + SPAN_BITS;
    localparam int unsigned OFF_ON  = OFF_PRS + VB;
    localparam int unsigned DIV_N   = (VB + 1 > SPAN_BITS) ? VB + 1 : SPAN_BITS;
    localparam int unsigned CMP_W   = (VB + 1 > THRESH_BITS) ? VB + 1 : THRESH_BITS;

    // Captured request.
    logic                   r_is_tick;
    logic [VB-1:0]          r_target;
    logic [STEP_BITS-1:0]   r_steps;
    logic [SPAN_BITS-1:0]   r_span;
    logic [VB-1:0]          r_present;
    logic                   r_chan_on;

    // Threshold register and ramp state.
    logic [THRESH_BITS-1:0] r_thresh;
    logic [VB-1:0]          r_level;
    logic [VB:0]            r_step;
    logic [STEP_BITS-1:0]   r_steps_left;
    logic [SPAN_BITS-1:0]   r_pause;
    logic [SPAN_BITS-1:0]   r_tick;

    // Pending result and output register.
    logic                   r_res_wr;
    logic [VB-1:0]          r_res_volt;
    logic [1:0]             r_res_st;
    logic                   r_res_last;
    logic                   r_out_valid;
    logic                   r_out_wr;
    logic [VB-1:0]          r_out_volt;
    logic [1:0]             r_out_st;
    logic                   r_out_last;

    logic [VB:0]            w_diff;
    logic                   w_neg;
    logic [VB:0]            w_mag;
    logic [SPAN_BITS-1:0]   w_tick1;
    logic [DIV_N-1:0]       w_qa;
    logic [DIV_N-1:0]       w_qb;
    logic                   w_div_done;
    logic [VB:0]            w_step_new;
    logic [VB-1:0]          n_level;
    logic                   n_res_wr;
    logic [VB-1:0]          n_res_volt;
    logic [1:0]             n_res_st;
    logic                   n_res_last;

    // Difference, its sign and magnitude.
    always_comb begin
        w_diff = {r_target[VB-1], r_target} - {r_present[VB-1], r_present};
        w_neg  = w_diff[VB];
        w_mag  = w_neg ? (~w_diff + 1'b1) : w_diff;
    end

    vrg_divider #(
        .N_BITS (DIV_N),
        .D_BITS (STEP_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.div_start),
        .i_dividend_a (DIV_N'(w_mag)),
        .i_dividend_b (DIV_N'(r_span)),
        .i_divisor    (r_steps),
        .o_done       (w_div_done),
        .o_quot_a     (w_qa),
        .o_quot_b     (w_qb)
    );

    // Signed step from the magnitude quotient, and the next level.
    always_comb begin
        w_step_new = w_neg ? (~w_qa[VB:0] + 1'b1) : w_qa[VB:0];
        w_tick1    = r_tick + 1'b1;
        if (i_cmd.ramp_load) begin
            n_level = r_present + w_step_new[VB-1:0];
        end else if (i_cmd.step_adv) begin
            n_level = r_level + r_step[VB-1:0];
        end else begin
            n_level = r_level;
        end
    end

    // Result fields for each kind of result.
    always_comb begin
        n_res_wr   = 1'b0;
        n_res_volt = '0;
        n_res_st   = ST_DONE;
        n_res_last = 1'b1;
        case (i_cmd.res_kind)
            RK_STEP: begin
                n_res_wr   = 1'b1;
                n_res_volt = n_level;
                n_res_st   = ST_STEP;
                n_res_last = 1'b0;
            end
            RK_DONE_LEVEL: begin
                n_res_volt = r_level;
            end
            RK_BUSY: begin
                n_res_st = ST_BUSY;
            end
            RK_REFUSED: begin
                n_res_st = ST_REFUSED;
            end
            RK_SET_ZERO: begin
                n_res_wr = 1'b1;
            end
            RK_SET_TARGET: begin
                n_res_wr   = 1'b1;
                n_res_volt = r_target;
            end
            default: begin
                n_res_wr = 1'b0;
            end
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_tick <= i_in_user;
            r_target  <= i_in_data[VB-1:0];
            r_steps   <= i_in_data[OFF_STP +: STEP_BITS];
            r_span    <= i_in_data[OFF_SPN +: SPAN_BITS];
            r_present <= i_in_data[OFF_PRS +: VB];
            r_chan_on <= i_in_data[OFF_ON];
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // Ramp state.
    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        if (i_cmd.ramp_load) begin
            r_step       <= w_step_new;
            r_pause      <= w_qb[SPAN_BITS-1:0];
            r_steps_left <= r_steps - 1'b1;
        end else if (i_cmd.step_adv) begin
            r_steps_left <= r_steps_left - 1'b1;
        end
        if (i_cmd.ramp_load || i_cmd.tick_clr) begin
            r_tick <= '0;
        end else if (i_cmd.tick_inc) begin
            r_tick <= w_tick1;
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_wr   <= n_res_wr;
            r_res_volt <= n_res_volt;
            r_res_st   <= n_res_st;
            r_res_last <= n_res_last;
        end
    end

    // Output register: holds a result item until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_wr   <= r_res_wr;
            r_out_volt <= r_res_volt;
            r_out_st   <= r_res_st;
            r_out_last <= r_res_last;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.is_tick         = r_is_tick;
        o_status.chan_on         = r_chan_on;
        o_status.target_zero     = (r_target == '0);
        o_status.below_thr       = (CMP_W'(w_mag) < CMP_W'(r_thresh));
        o_status.steps_zero      = (r_steps == '0);
        o_status.tick_hit        = !(w_tick1 < r_pause);
        o_status.steps_left_zero = (r_steps_left == '0);
        o_status.div_done        = w_div_done;
        o_status.out_free        = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_W'(r_out_volt);
    assign o_out_user  = {r_out_st, r_out_wr};
    assign o_out_last  = r_out_last;

endmodule

>>> rtl/vrg_ctrl.sv
// Controller of the voltage ramp generator: request decoding, ramp phase and
// the sequencing of divider, result and output register.
// Depends on vrg_pkg.
module vrg_ctrl
    import vrg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ramping;
    logic   n_ramping;

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_ramping = r_ramping;
        o_cmd     = '0;
        o_cmd.res_kind = RK_SET_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_EMIT;
                if (i_status.is_tick) begin
                    // A tick only matters while a ramp runs.
                    if (!r_ramping) begin
                        n_state = S_IDLE;
                    end else if (!i_status.tick_hit) begin
                        o_cmd.tick_inc = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.tick_clr = 1'b1;
                        o_cmd.res_load = 1'b1;
                        if (!i_status.steps_left_zero) begin
                            o_cmd.step_adv = 1'b1;
                            o_cmd.res_kind = RK_STEP;
                        end else begin
                            o_cmd.res_kind = RK_DONE_LEVEL;
                            n_ramping      = 1'b0;
                        end
                    end
                end else begin
                    o_cmd.res_load = 1'b1;
                    if (r_ramping) begin
                        o_cmd.res_kind = RK_BUSY;
                    end else if (!i_status.chan_on) begin
                        o_cmd.res_kind = i_status.target_zero ? RK_SET_ZERO : RK_REFUSED;
                    end else if (i_status.below_thr || i_status.steps_zero) begin
                        o_cmd.res_kind = RK_SET_TARGET;
                    end else begin
                        o_cmd.res_load  = 1'b0;
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // Quotients ready: load the ramp and send its first step.
                if (i_status.div_done) begin
                    o_cmd.ramp_load = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_kind  = RK_STEP;
                    n_ramping       = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and ramp phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ramping <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ramping <= n_ramping;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> rtl/voltage_ramp_generator.sv
// Top level of the linear voltage ramp generator.
// Depends on vrg_pkg, vrg_ctrl, vrg_datapath and vrg_divider.
//
// Use: the input stream carries ramp requests (tuser 0) and one-millisecond
// ticks (tuser 1). A request either sets its target at once, is refused while
// the channel is off and its target nonzero, returns busy during a ramp, or starts
// a ramp whose first step is sent at once; every following step, and the completion,
// is answered on the tick that ends its pause. Each item gives zero or one result.
// The configuration channel writes the ramp threshold; write it only while the
// block is idle. It is always ready.
// Sequence: one item is handled at a time. An item that needs no division is
// captured, evaluated, and loaded into the output register once that is free;
// the block is ready again after that load. A ramp start adds the serial
// divider, one quotient bit per cycle over max(VOLT_BITS + 1, SPAN_BITS) bits,
// between evaluation and the load of its first step. Ticks causing no result
// return to idle right after evaluation.
// Results pass through an output register, so the block takes the next item
// while a result waits; a further result waits until that register empties.
// Reset (synchronous, active low) ends any ramp, empties the output register
// and restores the threshold to 50000 mV.
module voltage_ramp_generator
    import vrg_pkg::*;
#(
    parameter int unsigned VOLT_BITS = 22,
    parameter int unsigned STEP_BITS = 16,
    parameter int unsigned SPAN_BITS = 20,
    parameter int unsigned IN_W  = ((2 * VOLT_BITS + STEP_BITS + SPAN_BITS + 1 + 7) / 8) * 8,
    parameter int unsigned OUT_W = ((VOLT_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Low bit up: target_mv, step_count, span_ms, present_mv, channel_on, zero fill.
    input  logic [IN_W-1:0]        s_axis_tdata,
    // req_type.
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Low bit up: voltage_out, zero fill.
    output logic [OUT_W-1:0]       m_axis_tdata,
    // Low bit up: write_voltage, status.
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [THRESH_BITS-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    vrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vrg_datapath #(
        .VOLT_BITS (VOLT_BITS),
        .STEP_BITS (STEP_BITS),
        .SPAN_BITS (SPAN_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // The threshold register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/vrg_checker.sv
// Port-level checks of the voltage ramp generator, bound to its top level.
// Depends on vrg_pkg and voltage_ramp_generator.
module vrg_checker
    import vrg_pkg::*;
#(
    parameter int unsigned OUT_W = 24
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [2:0]       m_axis_tuser,
    input logic             m_axis_tlast
);

    // A stalled result item holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // One item at a time: after an acceptance the input side is closed.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // Only ramp steps leave a request open.
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:1] != ST_STEP)))
        else $error("tlast disagrees with status");

    // Refused and busy answers write nothing and carry zero.
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] == ST_REFUSED || m_axis_tuser[2:1] == ST_BUSY)
            |-> !m_axis_tuser[0] && (m_axis_tdata == '0))
        else $error("refused or busy result writes a voltage");

endmodule

bind voltage_ramp_generator vrg_checker #(
    .OUT_W (OUT_W)
) u_vrg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> verif/testbench.sv
// Self-checking testbench for the linear voltage ramp generator.
// Drives requests and millisecond ticks, predicts every result item and checks it.
// Depends on vrg_pkg and voltage_ramp_generator.
`timescale 1ns / 1ps

module testbench
    import vrg_pkg::*;
;

    localparam int VOLT_W = 22;
    localparam int STEP_W = 16;
    localparam int SPAN_W = 20;
    localparam int IN_W = 88;
    localparam int OUT_W = 24;
    localparam int VOLT_MAX = 2000000;
    localparam int SPAN_MAX = 1048575;
    localparam int STEP_MAX = 65535;
    localparam int LONG_STEPS = 255;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int REPORT_LIMIT = 10;

    // Kinds of input item, as carried on tuser.
    localparam bit REQ_RAMP = 1'b0;
    localparam bit REQ_TICK = 1'b1;

    typedef struct {
        bit                        tick;
        logic signed [VOLT_W-1:0]  target;
        logic [STEP_W-1:0]         steps;
        logic [SPAN_W-1:0]         span;
        logic signed [VOLT_W-1:0]  present;
        bit                        on;
    } t_ramp_req;

    typedef struct {
        logic                      write;
        logic signed [VOLT_W-1:0]  volt;
        logic [1:0]                status;
        logic                      last;
    } t_ramp_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [THRESH_BITS-1:0] i_cfg_data;

    // Predicted state of the ramp generator.
    logic [THRESH_BITS-1:0] threshold_mv = THRESH_RESET;
    bit                     ramp_running = 1'b0;
    longint                 ramp_level = 0;
    longint                 ramp_step = 0;
    int unsigned            steps_remaining = 0;
    int unsigned            pause_ticks = 0;
    int unsigned            ticks_seen = 0;

    t_ramp_result pending_answers[$];
    int           answer_mismatches = 0;
    int           handled_items = 0;
    int           hold_off_cycles = 0;
    bit           no_idle = 1'b0;
    int           cycle_count = 0;

    voltage_ramp_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit, counted in clock cycles.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            m_axis_tready = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            m_axis_tready = no_idle || ($urandom_range(0, 99) >= 9);
        end
    end

    // Works out the result of one accepted item and advances the predicted state.
    function automatic bit compute_ramp_answer(input t_ramp_req r, output t_ramp_result res);
        longint target;
        longint present;
        longint diff;
        longint mag;
        res = '{1'b0, '0, ST_STEP, 1'b0};
        if (r.tick) begin
            if (!ramp_running)
                return 1'b0;
            ticks_seen = (ticks_seen + 1) & SPAN_MAX;
            if (ticks_seen < pause_ticks)
                return 1'b0;
            ticks_seen = 0;
            if (steps_remaining != 0) begin
                steps_remaining = steps_remaining - 1;
                ramp_level = ramp_level + ramp_step;
                res = '{1'b1, ramp_level[VOLT_W-1:0], ST_STEP, 1'b0};
                return 1'b1;
            end
            ramp_running = 1'b0;
            res = '{1'b0, ramp_level[VOLT_W-1:0], ST_DONE, 1'b1};
            return 1'b1;
        end
        if (ramp_running) begin
            res = '{1'b0, '0, ST_BUSY, 1'b1};
            return 1'b1;
        end
        target = longint'(r.target);
        present = longint'(r.present);
        diff = target - present;
        mag = (diff < 0) ? -diff : diff;
        if (!r.on) begin
            if (target != 0)
                res = '{1'b0, '0, ST_REFUSED, 1'b1};
            else
                res = '{1'b1, '0, ST_DONE, 1'b1};
            return 1'b1;
        end
        if (mag < longint'(threshold_mv) || r.steps == 0) begin
            res = '{1'b1, r.target, ST_DONE, 1'b1};
            return 1'b1;
        end
        // Start of a ramp: both quotients truncate toward zero.
        ramp_step = diff / longint'(r.steps);
        pause_ticks = int'(r.span) / int'(r.steps);
        steps_remaining = int'(r.steps) - 1;
        ticks_seen = 0;
        ramp_level = present + ramp_step;
        ramp_running = 1'b1;
        res = '{1'b1, ramp_level[VOLT_W-1:0], ST_STEP, 1'b0};
        return 1'b1;
    endfunction

    // True when a request would start a ramp under the present threshold.
    function automatic bit would_ramp(input t_ramp_req r);
        longint mag;
        mag = longint'(r.target) - longint'(r.present);
        if (mag < 0)
            mag = -mag;
        return r.on && r.steps != 0 && mag >= longint'(threshold_mv);
    endfunction

    function automatic t_ramp_req make_request(input int target, input int steps,
                                               input int span, input int present,
                                               input bit on);
        t_ramp_req r;
        r.tick = REQ_RAMP;
        r.target = VOLT_W'(target);
        r.steps = STEP_W'(steps);
        r.span = SPAN_W'(span);
        r.present = VOLT_W'(present);
        r.on = on;
        return r;
    endfunction

    // A tick with random content in the fields that it does not use.
    function automatic t_ramp_req make_tick();
        t_ramp_req r;
        r.tick = REQ_TICK;
        r.target = VOLT_W'($urandom);
        r.steps = STEP_W'($urandom);
        r.span = SPAN_W'($urandom);
        r.present = VOLT_W'($urandom);
        r.on = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic int random_volt();
        return int'($urandom_range(0, 2 * VOLT_MAX)) - VOLT_MAX;
    endfunction

    // Offers one item, waits for its acceptance and records the expected result.
    task automatic send_item(input t_ramp_req r);
        t_ramp_result ans;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, r.on, r.present, r.span, r.steps, r.target};
        s_axis_tuser = r.tick;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!(r.tick && !ramp_running))
            handled_items = handled_items + 1;
        if (compute_ramp_answer(r, ans))
            pending_answers.push_back(ans);
    endtask

    // Sends ticks until the ramp in progress has reported completion.
    task automatic finish_ramp();
        while (ramp_running)
            send_item(make_tick());
    endtask

    // Stops sending and waits until every result is in and the block is quiet.
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold_mv = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : check_answers
        t_ramp_result got;
        t_ramp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.write = m_axis_tuser[0];
            got.status = m_axis_tuser[2:1];
            got.volt = m_axis_tdata[VOLT_W-1:0];
            got.last = m_axis_tlast;
            if (pending_answers.size() == 0) begin
                answer_mismatches = answer_mismatches + 1;
                if (answer_mismatches <= REPORT_LIMIT)
                    $display("unexpected result: wr=%0b v=%0d st=%0d last=%0b",
                             got.write, got.volt, got.status, got.last);
            end else begin
                want = pending_answers.pop_front();
                if (got.write !== want.write || got.volt !== want.volt ||
                    got.status !== want.status || got.last !== want.last) begin
                    answer_mismatches = answer_mismatches + 1;
                    if (answer_mismatches <= REPORT_LIMIT)
                        $display({"mismatch: expected wr=%0b v=%0d st=%0d last=%0b,",
                                  " got wr=%0b v=%0d st=%0d last=%0b"},
                                 want.write, want.volt, want.status, want.last,
                                 got.write, got.volt, got.status, got.last);
                end
            end
        end
    end

    // Refusals, direct sets, threshold edges, short ramps and a busy request.
    task automatic test_direct_cases();
        write_threshold(THRESH_RESET);
        send_item(make_request(VOLT_MAX, 5, 10, 0, 1'b0));
        send_item(make_request(0, STEP_MAX, SPAN_MAX, -VOLT_MAX, 1'b0));
        send_item(make_request(-VOLT_MAX, 0, 0, -VOLT_MAX, 1'b0));
        send_item(make_request(1000, 4, 8, 0, 1'b1));
        send_item(make_request(-49999, 4, 8, 0, 1'b1));
        // Difference exactly at the threshold ramps; a one-step ramp.
        send_item(make_request(50000, 1, 0, 0, 1'b1));
        finish_ramp();
        // Tick while idle gives nothing.
        send_item(make_tick());
        // Zero step count sets the target directly.
        send_item(make_request(VOLT_MAX, 0, SPAN_MAX, -VOLT_MAX, 1'b1));
        // Full-scale single steps in both directions.
        send_item(make_request(VOLT_MAX, 1, 1, -VOLT_MAX, 1'b1));
        finish_ramp();
        send_item(make_request(-VOLT_MAX, 1, 0, VOLT_MAX, 1'b1));
        finish_ramp();
        // Negative step truncated toward zero, with a request during the ramp.
        send_item(make_request(-100001, 3, 7, 100000, 1'b1));
        send_item(make_request(5, 2, 2, 0, 1'b1));
        finish_ramp();
        // Pause of one.
        send_item(make_request(-300000, 2, 3, 300000, 1'b1));
        finish_ramp();
        settle_block();
    endtask

    // Random traffic after writing a threshold: mostly full ramps, some noise.
    task automatic test_random_at_threshold(input logic [THRESH_BITS-1:0] thr,
                                            input int n_items, input bit steady);
        int        first;
        int        pick;
        int        steps;
        int        span;
        int        present;
        t_ramp_req r;
        write_threshold(thr);
        no_idle = steady;
        first = handled_items;
        while (handled_items - first < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // A well-formed ramp with random content, run to completion.
                steps = ($urandom_range(0, 99) < 4) ? $urandom_range(7, 80)
                                                    : $urandom_range(1, 6);
                span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, steps * 6)
                                                   : $urandom_range(0, steps * 2);
                present = random_volt();
                r = make_request(random_volt(), steps, span, present, 1'b1);
                if ($urandom_range(0, 9) == 0)
                    r.target = VOLT_W'(present);
                if (!would_ramp(r))
                    r.target = VOLT_W'((present >= 0) ? -VOLT_MAX : VOLT_MAX);
                send_item(r);
                while (ramp_running) begin
                    if ($urandom_range(0, 99) < 8)
                        send_item(make_request(random_volt(), $urandom_range(0, STEP_MAX),
                                               $urandom_range(0, SPAN_MAX), random_volt(),
                                               1'($urandom_range(0, 1))));
                    else
                        send_item(make_tick());
                end
            end else if (pick < 85) begin
                // A lone request that never starts a ramp.
                r = make_request(($urandom_range(0, 4) == 0) ? 0 : random_volt(),
                                 ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, STEP_MAX),
                                 $urandom_range(0, SPAN_MAX), random_volt(),
                                 1'($urandom_range(0, 1)));
                if (would_ramp(r))
                    r.steps = '0;
                send_item(r);
            end else begin
                repeat ($urandom_range(1, 3)) send_item(make_tick());
            end
        end
        settle_block();
        no_idle = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the block stalls.
    task automatic test_output_stall();
        @(posedge i_clk);
        hold_off_cycles = 300;
        repeat (12)
            send_item(make_request(random_volt(), 0, $urandom_range(0, SPAN_MAX),
                                   random_volt(), 1'($urandom_range(0, 1))));
        settle_block();
    endtask

    // A long ramp sent without idling: full-scale swing, pause of zero.
    task automatic test_long_ramp();
        no_idle = 1'b1;
        send_item(make_request(VOLT_MAX, LONG_STEPS, LONG_STEPS - 1, -VOLT_MAX, 1'b1));
        finish_ramp();
        settle_block();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_RAMP;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_direct_cases();
        test_random_at_threshold(THRESH_RESET, 300, 1'b0);
        test_output_stall();
        test_random_at_threshold('0, 300, 1'b0);
        test_random_at_threshold(THRESH_BITS'(VOLT_MAX), 300, 1'b1);
        test_random_at_threshold(THRESH_BITS'($urandom_range(2, VOLT_MAX - 1)), 300, 1'b0);
        test_random_at_threshold(THRESH_BITS'(1), 300, 1'b0);
        test_long_ramp();

        if (answer_mismatches == 0 && pending_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
